// ===== sv/lkc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the LRU keyed cache table.
package lkc_pkg;

    localparam int KEY_W   = 64;
    localparam int PAY_W   = 64;
    localparam int ACT_W   = 2;
    localparam int LIMIT_W = 6;
    localparam int OCC_W   = 6;

    localparam logic [LIMIT_W-1:0] RESET_LIMIT = 6'd20;

    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PEEK   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [KEY_W-1:0] lookup_key;
        logic [PAY_W-1:0] new_payload;
    } t_req;

    typedef struct packed {
        logic             hit;
        logic [PAY_W-1:0] found_payload;
        logic             evicted;
        logic [OCC_W-1:0] occupancy;
    } t_rsp;

    // Control of the search accumulator: start clears it, en presents one entry.
    typedef struct packed {
        logic start;
        logic en;
    } t_scan_ctl;

endpackage

// ===== sv/lru_keyed_cache_table.sv =====
`timescale 1ns / 1ps
// Top level of the fully associative LRU keyed cache table.
//
// A request is taken when start is high and busy is low; its result appears
// on o_rsp for exactly one cycle with o_done high and cannot be held off, so
// the receiver must take it in that cycle. A clear request finishes at once:
// its result shows in the next cycle and busy never rises. Every other request
// walks the key/rank memory one entry a cycle: a search walk, a resolve step,
// then a second walk to rewrite the age ranks on a lookup hit or an insert,
// and a finish step. A peek, a lookup miss, or any request that leaves the
// order untouched skips the second walk. The result strobe comes in the first
// cycle that busy is low, and a new request may be taken in that very cycle.
// Each walk sweeps the single read port of the key/rank memory in full.
// The user must write the entry_limit register through i_cfg_we and
// i_cfg_wdata only while the block is idle; the block does not enforce this.
// Values above CAPACITY act as CAPACITY.
module lru_keyed_cache_table #(
    parameter int CAPACITY = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  lkc_pkg::t_req                 i_req,
    output logic                          o_done,
    output lkc_pkg::t_rsp                 o_rsp,
    input  logic                          i_cfg_we,
    input  logic [lkc_pkg::LIMIT_W-1:0]   i_cfg_wdata
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int RANK_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int KR_W   = lkc_pkg::KEY_W + RANK_W;
    localparam int CMP_W  = ((CNT_W > lkc_pkg::LIMIT_W) ? CNT_W : lkc_pkg::LIMIT_W) + 1;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SCAN    = 5'b00010,
        S_RESOLVE = 5'b00100,
        S_UPDATE  = 5'b01000,
        S_FINISH  = 5'b10000
    } t_state;

    // How the age ranks change on the rewrite walk.
    typedef enum logic [1:0] {
        UPD_NONE  = 2'd0,
        UPD_TOUCH = 2'd1,
        UPD_ADD   = 2'd2
    } t_upd;

    t_state                        r_state;
    lkc_pkg::t_req                 r_req;
    lkc_pkg::t_rsp                 r_rsp;
    logic                          r_done;
    logic [lkc_pkg::LIMIT_W-1:0]   r_limit;
    logic [CAPACITY-1:0]           r_valid;
    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              r_idx;

    // Decisions made once the search is over.
    t_upd                          r_kind,      n_kind;
    logic [IDX_W-1:0]              r_slot,      n_slot;
    logic                          r_set_en,    n_set_en;
    logic                          r_clr_en,    n_clr_en;
    logic [IDX_W-1:0]              r_clr_idx,   n_clr_idx;
    logic                          r_evicted,   n_evicted;
    logic [CNT_W-1:0]              r_new_count, n_new_count;
    logic [RANK_W-1:0]             r_slot_rank, n_slot_rank;

    logic                          n_done;
    logic [CAPACITY-1:0]           n_valid;

    logic                          w_accept;
    logic                          w_is_insert;
    logic [CNT_W-1:0]              w_prev;
    logic [IDX_W-1:0]              w_entry_idx;
    logic [IDX_W-1:0]              w_raddr;
    logic                          w_entry_valid;

    logic [KR_W-1:0]               w_kr_rdata;
    logic [lkc_pkg::KEY_W-1:0]     w_ent_key;
    logic [RANK_W-1:0]             w_ent_rank;
    logic                          w_kr_we;
    logic [KR_W-1:0]               w_kr_wdata;
    logic [lkc_pkg::PAY_W-1:0]     w_pay_rdata;
    logic                          w_pay_we;

    lkc_pkg::t_scan_ctl            w_scan_ctl;
    logic                          w_hit_found;
    logic [IDX_W-1:0]              w_hit_idx;
    logic [RANK_W-1:0]             w_hit_rank;
    logic                          w_free_found;
    logic [IDX_W-1:0]              w_free_idx;
    logic [IDX_W-1:0]              w_old1_idx;
    logic [IDX_W-1:0]              w_old2_idx;

    logic [CMP_W-1:0]              w_limit_sat;
    logic [CMP_W-1:0]              w_count_ext;

    assign w_accept    = start && !busy;
    assign w_is_insert = (r_req.action == lkc_pkg::ACT_INSERT);

    // The memory read is registered, so the counter value
    // k presents entry k - 1; the final count value only drains the pipeline.
    assign w_prev        = r_idx - CNT_W'(1);
    assign w_entry_idx   = w_prev[IDX_W-1:0];
    assign w_raddr       = (r_idx == CNT_W'(CAPACITY)) ? '0 : r_idx[IDX_W-1:0];
    assign w_entry_valid = r_valid[w_entry_idx];

    assign w_ent_key  = w_kr_rdata[RANK_W +: lkc_pkg::KEY_W];
    assign w_ent_rank = w_kr_rdata[RANK_W-1:0];

    assign w_scan_ctl.start = w_accept && (i_req.action != lkc_pkg::ACT_CLEAR);
    assign w_scan_ctl.en    = (r_state == S_SCAN) && (r_idx != '0);

    lkc_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_scan_ctl),
        .i_idx        (w_entry_idx),
        .i_valid      (w_entry_valid),
        .i_entry_key  (w_ent_key),
        .i_entry_rank (w_ent_rank),
        .i_key        (r_req.lookup_key),
        .i_count      (r_count),
        .o_hit_found  (w_hit_found),
        .o_hit_idx    (w_hit_idx),
        .o_hit_rank   (w_hit_rank),
        .o_free_found (w_free_found),
        .o_free_idx   (w_free_idx),
        .o_old1_idx   (w_old1_idx),
        .o_old2_idx   (w_old2_idx)
    );

    // Rank rewrite: the touched or new slot becomes most recent, and the
    // entries it passes age by one. Entries that do not change are not written.
    always_comb begin
        w_kr_we    = 1'b0;
        w_kr_wdata = w_kr_rdata;
        if ((r_state == S_UPDATE) && (r_idx != '0)) begin
            if (w_entry_idx == r_slot) begin
                w_kr_we = 1'b1;
                if (r_kind == UPD_ADD) begin
                    w_kr_wdata = {r_req.lookup_key, {RANK_W{1'b0}}};
                end else begin
                    w_kr_wdata = {w_ent_key, {RANK_W{1'b0}}};
                end
            end else if (w_entry_valid
                         && ((r_kind == UPD_ADD) || (w_ent_rank < r_slot_rank))) begin
                w_kr_we    = 1'b1;
                w_kr_wdata = {w_ent_key, w_ent_rank + RANK_W'(1)};
            end
        end
    end

    lkc_ram #(
        .WIDTH (KR_W),
        .DEPTH (CAPACITY)
    ) u_key_rank_ram (
        .i_clk   (i_clk),
        .i_we    (w_kr_we),
        .i_waddr (w_entry_idx),
        .i_wdata (w_kr_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_kr_rdata)
    );

    // The payload is written once the slot is chosen and is read at the
    // matching slot, which is stable from the end of the search on.
    assign w_pay_we = (r_state == S_RESOLVE) && w_is_insert;

    lkc_ram #(
        .WIDTH (lkc_pkg::PAY_W),
        .DEPTH (CAPACITY)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (w_pay_we),
        .i_waddr (n_slot),
        .i_wdata (r_req.new_payload),
        .i_raddr (w_hit_idx),
        .o_rdata (w_pay_rdata)
    );

    assign w_count_ext = CMP_W'(r_count);
    assign w_limit_sat = (CMP_W'(r_limit) > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY)
                                                              : CMP_W'(r_limit);

    // Outcome of a request once the search results are known.
    always_comb begin
        n_kind      = UPD_NONE;
        n_slot      = w_hit_idx;
        n_slot_rank = w_hit_rank;
        n_set_en    = 1'b0;
        n_clr_en    = 1'b0;
        n_clr_idx   = w_old1_idx;
        n_evicted   = 1'b0;
        n_new_count = r_count;
        if ((r_req.action == lkc_pkg::ACT_LOOKUP) && w_hit_found) begin
            n_kind = UPD_TOUCH;
        end else if (w_is_insert) begin
            if (w_hit_found) begin
                n_kind = UPD_TOUCH;
                if (w_count_ext > w_limit_sat) begin
                    // After the touch the oldest is the old oldest, unless the
                    // touched entry was itself the oldest.
                    n_evicted   = 1'b1;
                    n_clr_en    = 1'b1;
                    n_new_count = r_count - CNT_W'(1);
                    if (CNT_W'(w_hit_rank) == r_count - CNT_W'(1)) begin
                        n_clr_idx = (r_count == CNT_W'(1)) ? w_hit_idx : w_old2_idx;
                    end
                end
            end else if (!w_free_found) begin
                // Full table: the oldest slot is reused for the new key.
                n_kind    = UPD_ADD;
                n_slot    = w_old1_idx;
                n_evicted = 1'b1;
            end else begin
                n_kind      = UPD_ADD;
                n_slot      = w_free_idx;
                n_set_en    = 1'b1;
                n_new_count = r_count + CNT_W'(1);
                if (w_count_ext + CMP_W'(1) > w_limit_sat) begin
                    // With an empty table the new entry is itself the oldest.
                    n_evicted   = 1'b1;
                    n_clr_en    = 1'b1;
                    n_new_count = r_count;
                    n_clr_idx   = (r_count == '0) ? w_free_idx : w_old1_idx;
                end
            end
        end
    end

    // Valid bits at the end of a request. A self-evicted new entry is set and
    // cleared in the same step; the clear is applied last and wins.
    always_comb begin
        n_valid = r_valid;
        if (r_set_en) begin
            n_valid[r_slot] = 1'b1;
        end
        if (r_clr_en) begin
            n_valid[r_clr_idx] = 1'b0;
        end
    end

    // The strobe rises after the last cycle of a request, or right after a clear.
    assign n_done = (r_state == S_FINISH)
                    || (w_accept && (i_req.action == lkc_pkg::ACT_CLEAR));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_limit <= lkc_pkg::RESET_LIMIT;
            r_valid <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_done <= n_done;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_req <= i_req;
                        r_idx <= '0;
                        if (i_req.action == lkc_pkg::ACT_CLEAR) begin
                            r_valid <= '0;
                            r_count <= '0;
                            r_rsp   <= '0;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_idx == CNT_W'(CAPACITY)) begin
                        r_state <= S_RESOLVE;
                    end
                    r_idx <= r_idx + CNT_W'(1);
                end
                S_RESOLVE: begin
                    r_kind      <= n_kind;
                    r_slot      <= n_slot;
                    r_slot_rank <= n_slot_rank;
                    r_set_en    <= n_set_en;
                    r_clr_en    <= n_clr_en;
                    r_clr_idx   <= n_clr_idx;
                    r_evicted   <= n_evicted;
                    r_new_count <= n_new_count;
                    r_idx       <= '0;
                    r_state     <= (n_kind == UPD_NONE) ? S_FINISH : S_UPDATE;
                end
                S_UPDATE: begin
                    if (r_idx == CNT_W'(CAPACITY)) begin
                        r_state <= S_FINISH;
                    end
                    r_idx <= r_idx + CNT_W'(1);
                end
                S_FINISH: begin
                    r_valid <= n_valid;
                    r_count <= r_new_count;
                    r_rsp   <= '{hit:           w_hit_found,
                                 found_payload: (w_hit_found && !w_is_insert)
                                                ? w_pay_rdata
                                                : {lkc_pkg::PAY_W{1'b0}},
                                 evicted:       r_evicted,
                                 occupancy:     lkc_pkg::OCC_W'(r_new_count)};
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ===== sv/lkc_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
module lkc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/lkc_scan.sv =====
`timescale 1ns / 1ps
// Search accumulator: collects key match, free slot and the two oldest entries over a scan.
module lkc_scan #(
    parameter int CAPACITY = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lkc_pkg::t_scan_ctl                i_ctl,
    input  logic [$clog2(CAPACITY)-1:0]       i_idx,
    input  logic                              i_valid,
    input  logic [lkc_pkg::KEY_W-1:0]         i_entry_key,
    input  logic [$clog2(CAPACITY)-1:0]       i_entry_rank,
    input  logic [lkc_pkg::KEY_W-1:0]         i_key,
    input  logic [$clog2(CAPACITY+1)-1:0]     i_count,
    output logic                              o_hit_found,
    output logic [$clog2(CAPACITY)-1:0]       o_hit_idx,
    output logic [$clog2(CAPACITY)-1:0]       o_hit_rank,
    output logic                              o_free_found,
    output logic [$clog2(CAPACITY)-1:0]       o_free_idx,
    output logic [$clog2(CAPACITY)-1:0]       o_old1_idx,
    output logic [$clog2(CAPACITY)-1:0]       o_old2_idx
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic             r_hit_found;
    logic [IDX_W-1:0] r_hit_idx;
    logic [IDX_W-1:0] r_hit_rank;
    logic             r_free_found;
    logic [IDX_W-1:0] r_free_idx;
    logic [IDX_W-1:0] r_old1_idx;
    logic [IDX_W-1:0] r_old2_idx;

    logic [CNT_W-1:0] w_rank_ext;
    logic             w_is_old1;
    logic             w_is_old2;

    assign w_rank_ext = CNT_W'(i_entry_rank);
    assign w_is_old1  = i_valid && (i_count >= CNT_W'(1))
                        && (w_rank_ext == i_count - CNT_W'(1));
    assign w_is_old2  = i_valid && (i_count >= CNT_W'(2))
                        && (w_rank_ext == i_count - CNT_W'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_ctl.start) begin
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_ctl.en) begin
            // The lowest matching index wins, as does the lowest free slot.
            if (!r_hit_found && i_valid && (i_entry_key == i_key)) begin
                r_hit_found <= 1'b1;
                r_hit_idx   <= i_idx;
                r_hit_rank  <= i_entry_rank;
            end
            if (!r_free_found && !i_valid) begin
                r_free_found <= 1'b1;
                r_free_idx   <= i_idx;
            end
            if (w_is_old1) begin
                r_old1_idx <= i_idx;
            end
            if (w_is_old2) begin
                r_old2_idx <= i_idx;
            end
        end
    end

    assign o_hit_found  = r_hit_found;
    assign o_hit_idx    = r_hit_idx;
    assign o_hit_rank   = r_hit_rank;
    assign o_free_found = r_free_found;
    assign o_free_idx   = r_free_idx;
    assign o_old1_idx   = r_old1_idx;
    assign o_old2_idx   = r_old2_idx;

endmodule

// ===== sv/lkc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the LRU keyed cache table, bound to the top level.
module lkc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input lkc_pkg::t_req                 i_req,
    input logic                          o_done,
    input lkc_pkg::t_rsp                 o_rsp
);

    // A result is only shown once the block is free for the next request.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // A search request occupies the block in the following cycle.
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.action != lkc_pkg::ACT_CLEAR)) |=> (busy && !o_done))
        else $error("search request did not start");

    // A clear request reports an empty table in the next cycle.
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.action == lkc_pkg::ACT_CLEAR)) |=>
        (o_done && !o_rsp.hit && !o_rsp.evicted
         && (o_rsp.found_payload == '0) && (o_rsp.occupancy == '0)))
        else $error("clear result wrong");

    // The end of a request always brings its result.
    a_done_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("request finished without result");

    // Only an insert evicts, and an insert reports no payload.
    a_evict_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.evicted) |-> (o_rsp.found_payload == '0))
        else $error("eviction with payload");

endmodule

bind lru_keyed_cache_table lkc_checker u_lkc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
